// ===== hdl/pnf_pkg.sv =====
package pnf_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int TABLE_ENTRIES = 256;
    localparam int TAB_AW        = 8;

    localparam int CRD_W  = 32;
    localparam int OUT_W  = 18;
    localparam int FREQ_W = 23;
    localparam int OCTC_W = 4;
    localparam int PERS_W = 17;
    localparam int MODE_W = 2;

    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    // shared multiplier and internal value widths
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int TA_W    = FRAC_BITS + 1;
    localparam int FADE_W  = FRAC_BITS + 2;
    localparam int GRAD_W  = FRAC_BITS + 4;
    localparam int INNER_W = FRAC_BITS + 6;
    localparam int AMP_W   = 32;
    localparam int ASUM_W  = 33;
    localparam int TOT_W   = 56;
    localparam int RES_W   = TOT_W + 1;

    localparam logic [FREQ_W-1:0] RST_BASE_FREQ = 23'd65536;
    localparam logic [OCTC_W-1:0] RST_OCT_CNT   = 4'd1;
    localparam logic [PERS_W-1:0] RST_PERSIST   = 17'd32768;
    localparam logic [MODE_W-1:0] RST_MODE      = 2'd0;

    localparam logic [AMP_W-1:0]          AMP_ONE   = AMP_W'(65536);
    localparam logic signed [GRAD_W-1:0]  ONE_G     = GRAD_W'(1 << FRAC_BITS);
    localparam logic signed [GRAD_W-1:0]  HALF_G    = GRAD_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [MUL_W-1:0]   FADE_K15  = MUL_W'(15 * (1 << FRAC_BITS));
    localparam logic signed [INNER_W-1:0] FADE_K10  = INNER_W'(10 * (1 << FRAC_BITS));
    localparam logic signed [RES_W-1:0]   RES_MAX   = RES_W'(131071);
    localparam logic signed [RES_W-1:0]   RES_MIN   = -RES_W'(131072);

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic [MODE_W-1:0] MODE_BASIC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NORM  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ABS   = 2'd2;

    typedef enum logic [1:0] {
        REG_BASE_FREQ = 2'd0,
        REG_OCT_CNT   = 2'd1,
        REG_PERSIST   = 2'd2,
        REG_MODE      = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_FADE,
        ST_HASH,
        ST_GRAD,
        ST_BLEND,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

// ===== hdl/pnf_if.sv =====
interface pnf_in_if;
    import pnf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    func;
    logic [TAB_AW-1:0]       table_index;
    logic [TAB_AW-1:0]       table_value;
    logic signed [CRD_W-1:0] coord_x;
    logic signed [CRD_W-1:0] coord_y;
    logic signed [CRD_W-1:0] coord_z;

    modport source (output valid, func, table_index, table_value, coord_x, coord_y, coord_z,
                    input ready);
    modport sink (input valid, func, table_index, table_value, coord_x, coord_y, coord_z,
                  output ready);
endinterface

interface pnf_out_if;
    import pnf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink (input valid, noise_value, output ready);
endinterface

// ===== hdl/pnf_ram.sv =====
module pnf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/perlin_noise_fbm_3d_top.sv =====
// channel   dir  handshake      word
// i_in      in   valid/ready    func, table_index, table_value, coord_x/y/z
// o_out     out  valid/ready    noise_value
// apb       in   psel/penable   base_frequency, octave_count, persistence, sample_mode
//
// a load word is written to the permutation ram when taken; a sample runs per octave
// through scale, fade, permutation ram, gradient, blend and accumulate steps on one shared
// multiplier, with a shorter accumulate when only one octave is taken, then a bit-serial
// division when more than one octave is summed, between the idle and output states.
// the permutation ram has no reset and holds nothing defined until loaded.
// a finished result waits in the output register while the next word is taken;
// only a second result blocks until the first one has gone.
module perlin_noise_fbm_3d_top #(
    parameter int MAX_OCTAVES = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pnf_in_if.sink                      i_in,
    pnf_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pnf_pkg::CFG_AW-1:0]  paddr,
    input  logic [pnf_pkg::CFG_DW-1:0]  pwdata,
    output logic [pnf_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready
);
    import pnf_pkg::*;

    localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
    localparam int DCNT_W = $clog2(TOT_W);

    function automatic logic signed [GRAD_W-1:0] grad_fn(input logic [3:0] h,
                                                        input logic signed [GRAD_W-1:0] x,
                                                        input logic signed [GRAD_W-1:0] y,
                                                        input logic signed [GRAD_W-1:0] z);
        logic signed [GRAD_W-1:0] u;
        logic signed [GRAD_W-1:0] v;
        u = (h < 4'd8) ? x : y;
        if (h < 4'd4) begin
            v = y;
        end else if (h == 4'd12 || h == 4'd14) begin
            v = x;
        end else begin
            v = z;
        end
        grad_fn = (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_fn(input logic signed [RES_W-1:0] v);
        if (v > RES_MAX) begin
            sat_fn = OUT_W'(RES_MAX);
        end else if (v < RES_MIN) begin
            sat_fn = OUT_W'(RES_MIN);
        end else begin
            sat_fn = OUT_W'(v);
        end
    endfunction

    // configuration
    logic [FREQ_W-1:0] r_base_freq;
    logic [OCTC_W-1:0] r_oct_cnt;
    logic [PERS_W-1:0] r_persist;
    logic [MODE_W-1:0] r_mode;

    // control
    t_state            r_state, n_state;
    logic [3:0]        r_step, n_step;
    logic [1:0]        r_axis, n_axis;
    logic [OCT_W-1:0]  r_oct, n_oct;
    logic [OCT_W-1:0]  r_noct, n_noct;
    logic [DCNT_W-1:0] r_dcnt, n_dcnt;
    logic [3:0]        r_qcnt, n_qcnt;
    logic              r_ovalid, n_ovalid;

    // datapath
    logic signed [CRD_W-1:0]   r_crd [3], n_crd [3];
    logic [FRAC_BITS-1:0]      r_frac [3], n_frac [3];
    logic [TAB_AW-1:0]         r_cell [3], n_cell [3];
    logic signed [FADE_W-1:0]  r_fade [3], n_fade [3];
    logic signed [TA_W-1:0]    r_ta, n_ta;
    logic signed [INNER_W-1:0] r_tb, n_tb;
    logic [TAB_AW-1:0]         r_ha, n_ha, r_hb, n_hb;
    logic [TAB_AW-1:0]         r_haa, n_haa, r_hab, n_hab, r_hba, n_hba, r_hbb, n_hbb;
    logic [3:0]                r_hash [8], n_hash [8];
    logic signed [GRAD_W-1:0]  r_q [8], n_q [8];
    logic signed [GRAD_W-1:0]  r_oval, n_oval;
    logic [AMP_W-1:0]          r_amp, n_amp;
    logic [ASUM_W-1:0]         r_asum, n_asum;
    logic signed [TOT_W-1:0]   r_total, n_total;
    logic [TOT_W-1:0]          r_dq, n_dq;
    logic [ASUM_W-1:0]         r_rem, n_rem;
    logic                      r_dneg, n_dneg;
    logic signed [RES_W-1:0]   r_res, n_res;
    logic signed [OUT_W-1:0]   r_odata, n_odata;
    logic signed [PROD_W-1:0]  r_prod;

    // combinational
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [MUL_W-1:0]  fd_t;
    logic [63:0]              sc_s;
    logic                     sc_carry;
    logic [TAB_AW-1:0]        sc_cell;
    logic signed [GRAD_W-1:0] lerp_res, mode_val;
    logic signed [FADE_W-1:0] lerp_t;
    logic signed [GRAD_W-1:0] xc0, yc0, zc0;
    logic [ASUM_W:0]          div_sh, div_sub;
    logic                     div_ge;
    logic [TAB_AW-1:0]        ram_raddr, ram_rdata;
    logic                     in_acc, ram_we, last_oct;

    pnf_ram #(.WIDTH(TAB_AW), .DEPTH(TABLE_ENTRIES)) u_perm (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_in.table_index),
        .i_wdata (i_in.table_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // configuration port
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            REG_BASE_FREQ: prdata = CFG_DW'(r_base_freq);
            REG_OCT_CNT:   prdata = CFG_DW'(r_oct_cnt);
            REG_PERSIST:   prdata = CFG_DW'(r_persist);
            REG_MODE:      prdata = CFG_DW'(r_mode);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_freq <= RST_BASE_FREQ;
            r_oct_cnt   <= RST_OCT_CNT;
            r_persist   <= RST_PERSIST;
            r_mode      <= RST_MODE;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                REG_BASE_FREQ: r_base_freq <= pwdata[FREQ_W-1:0];
                REG_OCT_CNT:   r_oct_cnt   <= pwdata[OCTC_W-1:0];
                REG_PERSIST:   r_persist   <= pwdata[PERS_W-1:0];
                REG_MODE:      r_mode      <= pwdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // shared helpers
    assign in_acc   = i_in.valid && i_in.ready;
    assign prod_sh  = r_prod >>> FRAC_BITS;
    assign fd_t     = MUL_W'(r_frac[0]);
    assign sc_s     = r_prod[63:0] << r_oct;
    assign sc_carry = r_crd[2][CRD_W-1] && (r_base_freq != '0)
                      && (sc_s[2*FRAC_BITS-1:0] != '0);
    assign sc_cell  = sc_s[2*FRAC_BITS +: TAB_AW] + TAB_AW'(sc_carry);
    assign lerp_res = r_q[0] + GRAD_W'(prod_sh);
    assign last_oct = (OCT_W'(r_oct + 1'b1) == r_noct);
    assign xc0      = GRAD_W'(r_frac[0]);
    assign yc0      = GRAD_W'(r_frac[1]);
    assign zc0      = GRAD_W'(r_frac[2]);
    assign div_sh   = {r_rem, r_dq[TOT_W-1]};
    assign div_ge   = div_sh >= {1'b0, r_asum};
    assign div_sub  = div_sh - {1'b0, r_asum};

    always_comb begin
        if (r_step[3:1] < 3'd4) begin
            lerp_t = r_fade[0];
        end else if (r_step[3:1] < 3'd6) begin
            lerp_t = r_fade[1];
        end else begin
            lerp_t = r_fade[2];
        end
    end

    always_comb begin
        case (r_mode)
            MODE_NORM: mode_val = (lerp_res >>> 1) + HALF_G;
            MODE_ABS:  mode_val = lerp_res[GRAD_W-1] ? -lerp_res : lerp_res;
            default:   mode_val = lerp_res;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_acc && i_in.func == FUNC_SAMPLE) n_state = ST_SCALE;
            ST_SCALE: if (r_step == 4'd3) n_state = ST_FADE;
            ST_FADE:  if (r_step == 4'd4 && r_axis == 2'd2) n_state = ST_HASH;
            ST_HASH:  if (r_step == 4'd14) n_state = ST_GRAD;
            ST_GRAD:  n_state = ST_BLEND;
            ST_BLEND: if (r_step == 4'd13) n_state = ST_ACC;
            ST_ACC: begin
                if (r_step == 4'd0 && r_noct <= OCT_W'(1)) begin
                    n_state = ST_OUT;
                end else if (r_step == 4'd2) begin
                    n_state = last_oct ? ST_DIV : ST_SCALE;
                end
            end
            ST_DIV:   if (r_dcnt == DCNT_W'(TOT_W - 1)) n_state = ST_OUT;
            ST_OUT:   if (!r_ovalid || o_out.ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs: handshakes, ram port, multiplier operands
    always_comb begin
        i_in.ready      = (r_state == ST_IDLE);
        o_out.valid     = r_ovalid;
        o_out.noise_value = r_odata;
        ram_we          = in_acc && i_in.func == FUNC_LOAD;
        ram_raddr       = '0;
        mul_a           = '0;
        mul_b           = '0;
        unique case (r_state)
            ST_SCALE: begin
                mul_a = MUL_W'(r_crd[0]);
                mul_b = MUL_W'(r_base_freq);
            end
            ST_FADE: begin
                case (r_step)
                    4'd0: begin
                        mul_a = fd_t;
                        mul_b = fd_t;
                    end
                    4'd1: begin
                        mul_a = fd_t;
                        mul_b = (fd_t <<< 2) + (fd_t <<< 1) - FADE_K15;
                    end
                    4'd2: begin
                        mul_a = MUL_W'(r_ta);
                        mul_b = fd_t;
                    end
                    4'd3: begin
                        mul_a = MUL_W'(prod_sh);
                        mul_b = MUL_W'(r_tb);
                    end
                    default: ;
                endcase
            end
            ST_HASH: begin
                case (r_step)
                    4'd0:    ram_raddr = r_cell[0];
                    4'd1:    ram_raddr = r_cell[0] + 1'b1;
                    4'd2:    ram_raddr = r_ha;
                    4'd3:    ram_raddr = r_ha + 1'b1;
                    4'd4:    ram_raddr = r_hb;
                    4'd5:    ram_raddr = r_hb + 1'b1;
                    4'd6:    ram_raddr = r_haa;
                    4'd7:    ram_raddr = r_hba;
                    4'd8:    ram_raddr = r_hab;
                    4'd9:    ram_raddr = r_hbb;
                    4'd10:   ram_raddr = r_haa + 1'b1;
                    4'd11:   ram_raddr = r_hba + 1'b1;
                    4'd12:   ram_raddr = r_hab + 1'b1;
                    4'd13:   ram_raddr = r_hbb + 1'b1;
                    default: ram_raddr = '0;
                endcase
            end
            ST_BLEND: begin
                if (!r_step[0]) begin
                    mul_a = MUL_W'(lerp_t);
                    mul_b = MUL_W'(r_q[1]) - MUL_W'(r_q[0]);
                end
            end
            ST_ACC: begin
                if (r_step == 4'd0) begin
                    mul_a = MUL_W'(r_oval);
                    mul_b = MUL_W'(r_amp);
                end else begin
                    mul_a = MUL_W'(r_amp);
                    mul_b = MUL_W'(r_persist);
                end
            end
            default: ;
        endcase
    end

    // register updates
    always_comb begin
        n_step   = (n_state != r_state) ? 4'd0 : r_step + 1'b1;
        n_axis   = r_axis;
        n_oct    = r_oct;
        n_noct   = r_noct;
        n_dcnt   = r_dcnt;
        n_qcnt   = r_qcnt;
        n_ovalid = r_ovalid && !o_out.ready;
        n_crd    = r_crd;
        n_frac   = r_frac;
        n_cell   = r_cell;
        n_fade   = r_fade;
        n_ta     = r_ta;
        n_tb     = r_tb;
        n_ha     = r_ha;
        n_hb     = r_hb;
        n_haa    = r_haa;
        n_hab    = r_hab;
        n_hba    = r_hba;
        n_hbb    = r_hbb;
        n_hash   = r_hash;
        n_q      = r_q;
        n_oval   = r_oval;
        n_amp    = r_amp;
        n_asum   = r_asum;
        n_total  = r_total;
        n_dq     = r_dq;
        n_rem    = r_rem;
        n_dneg   = r_dneg;
        n_res    = r_res;
        n_odata  = r_odata;

        unique case (r_state)
            ST_IDLE: begin
                n_crd[0] = i_in.coord_x;
                n_crd[1] = i_in.coord_y;
                n_crd[2] = i_in.coord_z;
                n_noct   = (int'(r_oct_cnt) > MAX_OCTAVES) ? OCT_W'(MAX_OCTAVES)
                                                            : OCT_W'(r_oct_cnt);
                n_oct    = '0;
                n_axis   = '0;
                n_amp    = AMP_ONE;
                n_asum   = '0;
                n_total  = '0;
            end
            ST_SCALE: begin
                if (r_step != 4'd3) begin
                    n_crd[0] = r_crd[1];
                    n_crd[1] = r_crd[2];
                    n_crd[2] = r_crd[0];
                end
                if (r_step != 4'd0) begin
                    n_frac[0] = r_frac[1];
                    n_frac[1] = r_frac[2];
                    n_frac[2] = sc_s[FRAC_BITS +: FRAC_BITS];
                    n_cell[0] = r_cell[1];
                    n_cell[1] = r_cell[2];
                    n_cell[2] = sc_cell;
                end
                n_axis = '0;
            end
            ST_FADE: begin
                case (r_step)
                    4'd1: n_ta = TA_W'(prod_sh);
                    4'd2: n_tb = INNER_W'(prod_sh) + FADE_K10;
                    4'd4: begin
                        n_fade[0] = r_fade[1];
                        n_fade[1] = r_fade[2];
                        n_fade[2] = FADE_W'(prod_sh);
                        n_frac[0] = r_frac[1];
                        n_frac[1] = r_frac[2];
                        n_frac[2] = r_frac[0];
                        n_axis    = r_axis + 1'b1;
                        n_step    = 4'd0;
                    end
                    default: ;
                endcase
            end
            ST_HASH: begin
                case (r_step)
                    4'd0: ;
                    4'd1: n_ha  = ram_rdata + r_cell[1];
                    4'd2: n_hb  = ram_rdata + r_cell[1];
                    4'd3: n_haa = ram_rdata + r_cell[2];
                    4'd4: n_hab = ram_rdata + r_cell[2];
                    4'd5: n_hba = ram_rdata + r_cell[2];
                    4'd6: n_hbb = ram_rdata + r_cell[2];
                    default: begin
                        // corner hashes arrive in corner order
                        for (int i = 0; i < 7; i++) begin
                            n_hash[i] = r_hash[i+1];
                        end
                        n_hash[7] = ram_rdata[3:0];
                    end
                endcase
            end
            ST_GRAD: begin
                for (int i = 0; i < 8; i++) begin
                    n_q[i] = grad_fn(r_hash[i],
                                     (i % 2 == 1) ? xc0 - ONE_G : xc0,
                                     ((i / 2) % 2 == 1) ? yc0 - ONE_G : yc0,
                                     (i / 4 == 1) ? zc0 - ONE_G : zc0);
                end
                n_qcnt = 4'd8;
            end
            ST_BLEND: begin
                if (r_step[0]) begin
                    // pop the pair at the head, append the blend at the tail
                    for (int i = 0; i < 8; i++) begin
                        if (i < 6 && 4'(i) < r_qcnt - 4'd2) begin
                            n_q[i] = r_q[3'(i + 2)];
                        end else if (4'(i) == r_qcnt - 4'd2) begin
                            n_q[i] = lerp_res;
                        end
                    end
                    n_qcnt = r_qcnt - 4'd1;
                    if (r_step == 4'd13) begin
                        n_oval = mode_val;
                    end
                end
            end
            ST_ACC: begin
                case (r_step)
                    4'd0: n_res = RES_W'(r_oval);
                    4'd1: begin
                        n_total = r_total + TOT_W'(r_prod);
                        n_asum  = r_asum + ASUM_W'(r_amp);
                    end
                    4'd2: begin
                        n_amp  = r_prod[16 +: AMP_W];
                        n_oct  = OCT_W'(r_oct + 1'b1);
                        n_dq   = r_total[TOT_W-1] ? $unsigned(-r_total) : $unsigned(r_total);
                        n_dneg = r_total[TOT_W-1];
                        n_rem  = '0;
                        n_dcnt = '0;
                    end
                    default: ;
                endcase
            end
            ST_DIV: begin
                n_rem  = div_ge ? div_sub[ASUM_W-1:0] : div_sh[ASUM_W-1:0];
                n_dq   = {r_dq[TOT_W-2:0], div_ge};
                n_dcnt = r_dcnt + 1'b1;
                n_res  = r_dneg ? -$signed({1'b0, n_dq}) : $signed({1'b0, n_dq});
            end
            ST_OUT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_odata  = sat_fn(r_res);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_axis   <= '0;
            r_oct    <= '0;
            r_noct   <= '0;
            r_dcnt   <= '0;
            r_qcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_axis   <= n_axis;
            r_oct    <= n_oct;
            r_noct   <= n_noct;
            r_dcnt   <= n_dcnt;
            r_qcnt   <= n_qcnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= mul_a * mul_b;
        r_crd   <= n_crd;
        r_frac  <= n_frac;
        r_cell  <= n_cell;
        r_fade  <= n_fade;
        r_ta    <= n_ta;
        r_tb    <= n_tb;
        r_ha    <= n_ha;
        r_hb    <= n_hb;
        r_haa   <= n_haa;
        r_hab   <= n_hab;
        r_hba   <= n_hba;
        r_hbb   <= n_hbb;
        r_hash  <= n_hash;
        r_q     <= n_q;
        r_oval  <= n_oval;
        r_amp   <= n_amp;
        r_asum  <= n_asum;
        r_total <= n_total;
        r_dq    <= n_dq;
        r_rem   <= n_rem;
        r_dneg  <= n_dneg;
        r_res   <= n_res;
        r_odata <= n_odata;
    end
endmodule
